/* hw/rtl/per_tenant_departure_time_pacer_assert.svh */
// Assertion macros shared by the pacer RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef PER_TENANT_DEPARTURE_TIME_PACER_ASSERT_SVH
`define PER_TENANT_DEPARTURE_TIME_PACER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PTDTP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PTDTP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ptdtp_pkg.sv */
// Types and constants for the per-tenant departure-time pacer.
// No dependencies; imported by every pacer module.
package ptdtp_pkg;

    localparam int ETHERTYPE_W   = 16;
    localparam int BYTES_W       = 18;
    localparam int IDENT_W       = 32;
    localparam int TIME_W        = 64;
    localparam int RATE_W        = 40;
    localparam int NS_PER_SEC_W  = 30;
    localparam int DIVIDEND_W    = 51;   // len * 8e9 < 2^51
    localparam int DIV_RADIX     = 3;    // quotient bits per cycle
    localparam int DIV_STEPS     = DIVIDEND_W / DIV_RADIX;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam int S_TDATA_W     = 152;  // 149 bits of fields, padded to bytes
    localparam int M_TDATA_W     = 72;   // 66 bits of fields, padded to bytes

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = RATE_W;

    localparam logic [ETHERTYPE_W-1:0]  ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [BYTES_W-1:0]      MIN_HEADER_BYTES = 18'd34;
    localparam logic [RATE_W-1:0]       DEFAULT_RATE_BPS = 40'd10000000;
    localparam logic [NS_PER_SEC_W-1:0] NS_PER_SEC       = 30'd1000000000;
    localparam logic [IDENT_W-1:0]      RESET_IDENTITY   = 32'd5001;

    localparam logic [CFG_INDEX_W-1:0] CFG_PACED_IDENTITY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_PRESENT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TENANT_RATE    = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_STAMP = 2'd1,
        VERDICT_DROP  = 2'd2
    } verdict_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic eval;      // classify, pick base, load the divider
        logic div_step;  // advance the divider
        logic finish;    // load the output register, commit state
    } ptdtp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_stamp;  // classification in eval wants a departure time
        logic div_last;  // divider runs its final cycle
        logic out_free;  // output register can take a result
    } ptdtp_sts_t;

endpackage

/* hw/rtl/ptdtp_div.sv */
// Iterative restoring divider, DIV_RADIX quotient bits per cycle while step is high.
// Depends on ptdtp_pkg.
module ptdtp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              step,
    input  logic [ptdtp_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [ptdtp_pkg::RATE_W-1:0]      divisor,
    output logic [ptdtp_pkg::DIVIDEND_W-1:0]  quotient,
    output logic                              last
);
    import ptdtp_pkg::*;

    logic [DIVIDEND_W-1:0] qr_reg, qr_next;
    logic [RATE_W-1:0]     rem_reg, rem_next;
    logic [RATE_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;

    always_comb
    begin
        logic [RATE_W:0] trial;
        qr_next  = qr_reg;
        rem_next = rem_reg;
        for (int k = 0; k < DIV_RADIX; k++)
        begin
            trial   = {rem_next, qr_next[DIVIDEND_W-1]};
            qr_next = {qr_next[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial      = trial - {1'b0, dsr_reg};
                qr_next[0] = 1'b1;
            end
            rem_next = trial[RATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            qr_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (step)
        begin
            qr_reg  <= qr_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = qr_reg;
    assign last     = step && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

/* hw/rtl/ptdtp_ctrl.sv */
// Sequencing state machine of the pacer.
// Depends on ptdtp_pkg; drives the datapath through ptdtp_cmd_t.
module ptdtp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  ptdtp_pkg::ptdtp_sts_t  sts,
    output ptdtp_pkg::ptdtp_cmd_t  cmd
);
    import ptdtp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = sts.is_stamp ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.eval     = (state_reg == S_EVAL);
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.finish   = (state_reg == S_DONE) && sts.out_free;

endmodule

/* hw/rtl/ptdtp_dp.sv */
// Datapath of the pacer: config registers, classification, delay, output register.
// Depends on ptdtp_pkg and ptdtp_div.
module ptdtp_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptdtp_pkg::ptdtp_cmd_t               cmd,
    output ptdtp_pkg::ptdtp_sts_t               sts,
    input  logic                                cfg_we,
    input  logic [ptdtp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ptdtp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [ptdtp_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ptdtp_pkg::M_TDATA_W-1:0]     m_tdata
);
    import ptdtp_pkg::*;

    // configuration
    logic [IDENT_W-1:0] paced_identity_reg;
    logic               rate_present_reg;
    logic [RATE_W-1:0]  tenant_rate_reg;

    // captured transaction
    logic [ETHERTYPE_W-1:0] ethertype_reg;
    logic [BYTES_W-1:0]     linear_bytes_reg;
    logic [BYTES_W-1:0]     packet_length_reg;
    logic                   identity_found_reg;
    logic [IDENT_W-1:0]     identity_reg;
    logic [TIME_W-1:0]      now_ns_reg;

    // pacing state
    logic [TIME_W-1:0] last_departure_reg;
    logic              tenant_seen_reg;

    // per-item working values
    verdict_t          verdict_reg, verdict_next;
    logic [TIME_W-1:0] base_reg;

    // output register
    logic              m_valid_reg;
    verdict_t          m_verdict_reg;
    logic [TIME_W-1:0] m_departure_reg;

    logic [DIVIDEND_W-1:0]              dividend;
    logic [BYTES_W+NS_PER_SEC_W-1:0]    len_ns;
    logic [RATE_W-1:0]                  divisor;
    logic [DIVIDEND_W-1:0]              quotient;
    logic                               div_last;
    logic [TIME_W-1:0]                  departure;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paced_identity_reg <= RESET_IDENTITY;
            rate_present_reg   <= 1'b0;
            tenant_rate_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PACED_IDENTITY: paced_identity_reg <= cfg_data[IDENT_W-1:0];
                CFG_RATE_PRESENT:   rate_present_reg   <= cfg_data[0];
                CFG_TENANT_RATE:    tenant_rate_reg    <= cfg_data[RATE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ethertype_reg      <= s_tdata[15:0];
            linear_bytes_reg   <= s_tdata[33:16];
            packet_length_reg  <= s_tdata[51:34];
            identity_found_reg <= s_tdata[52];
            identity_reg       <= s_tdata[84:53];
            now_ns_reg         <= s_tdata[148:85];
        end
    end

    // Classify the captured packet.
    always_comb
    begin
        verdict_next = VERDICT_PASS;
        if ((ethertype_reg == ETHERTYPE_IPV4) && (linear_bytes_reg >= MIN_HEADER_BYTES)
            && identity_found_reg && (identity_reg == paced_identity_reg))
        begin
            if (rate_present_reg && (tenant_rate_reg == '0))
            begin
                verdict_next = VERDICT_DROP;
            end
            else
            begin
                verdict_next = VERDICT_STAMP;
            end
        end
    end

    // len * 8e9 = (len * 1e9) << 3
    assign len_ns   = packet_length_reg * NS_PER_SEC;
    assign dividend = {len_ns[DIVIDEND_W-4:0], 3'b000};
    assign divisor  = rate_present_reg ? tenant_rate_reg : DEFAULT_RATE_BPS;

    ptdtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.eval),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .last     (div_last)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            verdict_reg <= verdict_next;
            if (tenant_seen_reg && (last_departure_reg > now_ns_reg))
            begin
                base_reg <= last_departure_reg;
            end
            else
            begin
                base_reg <= now_ns_reg;
            end
        end
    end

    assign departure = base_reg + TIME_W'(quotient);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_departure_reg <= '0;
            tenant_seen_reg    <= 1'b0;
        end
        else if (cmd.finish && (verdict_reg == VERDICT_STAMP))
        begin
            last_departure_reg <= departure;
            tenant_seen_reg    <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_verdict_reg   <= verdict_reg;
            m_departure_reg <= (verdict_reg == VERDICT_STAMP) ? departure : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_departure_reg, m_verdict_reg};

    assign sts.is_stamp = (verdict_next == VERDICT_STAMP);
    assign sts.div_last = div_last;
    assign sts.out_free = !m_valid_reg || m_tready;

endmodule

/* hw/rtl/per_tenant_departure_time_pacer.sv */
// Top level of the per-tenant earliest-departure-time pacer.
// Depends on ptdtp_pkg, ptdtp_ctrl, ptdtp_dp and the assertion macro header.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------------
//   s_*     | in        | packet metadata: ethertype, header bytes, length, identity, now
//   m_*     | out       | verdict and departure time, one transaction per packet
//   cfg_*   | in        | write-only registers: paced identity, rate present, rate
//
// A packet that passes or drops goes through capture, classify and the commit; a
// stamped packet goes through capture, classify, the 3-bit-per-cycle divider that
// forms length*8e9/rate, then the commit into the output register.
// One packet is in flight at a time; s_tready is high only while idle, and the
// next packet is taken while a finished result still waits on m_*.
// A stall on m_tready holds the result; the commit waits for the slot to free.
// Reset (rst_n, asynchronous) clears the pacing state and restores the registers.

`include "per_tenant_departure_time_pacer_assert.svh"

module per_tenant_departure_time_pacer (
    input  logic                                clk,
    input  logic                                rst_n,
    // cfg_index: 0 paced_identity, 1 rate_entry_present, 2 tenant_rate_bps
    input  logic                                cfg_we,
    input  logic [ptdtp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ptdtp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0 up: ethertype[15:0], linear_bytes[33:16],
    // packet_length[51:34], identity_found[52], identity[84:53],
    // now_ns[148:85], zero pad[151:149]
    input  logic [ptdtp_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0 up: verdict[1:0], departure_time[65:2], zero pad[71:66]
    output logic [ptdtp_pkg::M_TDATA_W-1:0]     m_tdata
);
    import ptdtp_pkg::*;

    ptdtp_cmd_t cmd;
    ptdtp_sts_t sts;

    // Sequence one packet at a time through classify, divide and commit.
    ptdtp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold registers, pacing state, divider and the output register.
    ptdtp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A captured transaction blocks the input until its result commits.
    `PTDTP_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second packet accepted while busy")

    // Pass and drop results carry a zero departure time.
    `PTDTP_ASSERT_IMP(a_zero_departure, m_tvalid && (m_tdata[1:0] != VERDICT_STAMP), m_tdata[65:2] == '0, "nonzero departure on unstamped result")

    // Only the three defined verdicts leave the block.
    `PTDTP_ASSERT_IMP(a_verdict_legal, m_tvalid, (m_tdata[1:0] == VERDICT_PASS) || (m_tdata[1:0] == VERDICT_STAMP) || (m_tdata[1:0] == VERDICT_DROP), "undefined verdict")

    // A commit never overwrites a result still waiting on the output.
    `PTDTP_ASSERT_IMP(a_no_overwrite, cmd.finish, !m_tvalid || m_tready, "result overwritten")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for per_tenant_departure_time_pacer: directed and random packet
// metadata scored against an in-bench pacing predictor, one result transaction per packet.
// Depends on ptdtp_pkg and the pacer RTL; needs no files or arguments.
module testbench;
    import ptdtp_pkg::*;

    // Index 3 is decoded by nobody; a write there must leave every register alone.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int RANDOM_PHASES     = 12;
    localparam int PACKETS_PER_PHASE = 130;
    localparam int DRAIN_CYCLES      = 40;
    localparam int DRAIN_LIMIT       = 20000;
    localparam int PRINT_CAP         = 60;

    // Packet metadata, most significant field first so the packed layout matches s_tdata.
    typedef struct packed {
        logic [TIME_W-1:0]      now_ns;
        logic [IDENT_W-1:0]     identity;
        logic                   identity_found;
        logic [BYTES_W-1:0]     packet_length;
        logic [BYTES_W-1:0]     linear_bytes;
        logic [ETHERTYPE_W-1:0] ethertype;
    } pkt_meta_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [TIME_W-1:0] departure;
    } verdict_rec_t;

    localparam int S_PAD_W = S_TDATA_W - $bits(pkt_meta_t);

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // s_tdata from bit 0 up: ethertype, linear_bytes, packet_length, identity_found,
    // identity, now_ns, zero pad
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // m_tdata from bit 0 up: verdict, departure_time, zero pad
    logic [M_TDATA_W-1:0]   m_tdata;

    // Packets waiting for the driver, and verdicts the pacer still owes.
    pkt_meta_t    pkts_to_send[$];
    verdict_rec_t verdicts_due[$];
    pkt_meta_t    pkt_on_bus;

    // Predictor copy of the registers and the pacing state.
    logic [IDENT_W-1:0] paced_id_shadow     = RESET_IDENTITY;
    logic               rate_present_shadow = 1'b0;
    logic [RATE_W-1:0]  rate_shadow         = '0;
    logic [TIME_W-1:0]  last_stamp          = '0;
    logic               tenant_stamped      = 1'b0;

    logic [TIME_W-1:0]  wall_ns = 64'd1000000;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int n_pass         = 0;
    int n_stamp        = 0;
    int n_drop         = 0;
    int reg_writes     = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    per_tenant_departure_time_pacer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic flag_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
        if (mismatches < PRINT_CAP)
        begin
            $display("[%0t] result %0d: %s got %0h want %0h", $time, results_seen, what,
                     got, want);
        end
        mismatches++;
    endtask

    // Work out the verdict and departure time for one accepted packet, then advance
    // the pacing state exactly as the block must.
    task automatic predict_verdict(input pkt_meta_t p);
        verdict_rec_t r;
        logic [TIME_W-1:0] rate;
        logic [TIME_W-1:0] len64;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] base;
        r.verdict   = VERDICT_PASS;
        r.departure = '0;
        if (p.ethertype == ETHERTYPE_IPV4 && p.linear_bytes >= MIN_HEADER_BYTES
            && p.identity_found && p.identity == paced_id_shadow)
        begin
            if (rate_present_shadow && rate_shadow == '0)
            begin
                r.verdict = VERDICT_DROP;
            end
            else
            begin
                rate  = rate_present_shadow ? rate_shadow : DEFAULT_RATE_BPS;
                len64 = p.packet_length;
                // len * 8e9 stays below 2^51, so 64 bits hold it
                delay = (len64 * 64'd8 * NS_PER_SEC) / rate;
                // the very first stamp ignores the stored time
                base  = (tenant_stamped && last_stamp > p.now_ns) ? last_stamp : p.now_ns;
                last_stamp     = base + delay;   // wraps at 64 bits
                tenant_stamped = 1'b1;
                r.verdict   = VERDICT_STAMP;
                r.departure = last_stamp;
            end
        end
        case (r.verdict)
            VERDICT_STAMP: n_stamp++;
            VERDICT_DROP:  n_drop++;
            default:       n_pass++;
        endcase
        verdicts_due.push_back(r);
    endtask

    function automatic pkt_meta_t mk_pkt(input logic [ETHERTYPE_W-1:0] etype,
                                         input logic [BYTES_W-1:0] linear,
                                         input logic [BYTES_W-1:0] len,
                                         input logic found,
                                         input logic [IDENT_W-1:0] ident,
                                         input logic [TIME_W-1:0] now);
        pkt_meta_t p;
        p.ethertype      = etype;
        p.linear_bytes   = linear;
        p.packet_length  = len;
        p.identity_found = found;
        p.identity       = ident;
        p.now_ns         = now;
        return p;
    endfunction

    // Draw one random packet: mostly well-formed paced traffic on a running wall
    // clock, the rest broken in one field or random throughout.
    function automatic pkt_meta_t draw_packet();
        pkt_meta_t p;
        logic [63:0] r64;
        logic [31:0] r32;
        r64 = {$urandom, $urandom};
        r32 = $urandom;
        // Advance the wall clock; now and then jump anywhere, or close to the wrap.
        if ($urandom_range(0, 19) == 0)
            wall_ns = r64;
        else if ($urandom_range(0, 49) == 0)
            wall_ns = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2000000);
        else
            wall_ns = wall_ns + $urandom_range(0, 20000);

        p.ethertype = ETHERTYPE_IPV4;
        if ($urandom_range(0, 1) == 0)
            p.linear_bytes = r32[5:0] % 27 + MIN_HEADER_BYTES;
        else
            p.linear_bytes = r32[23:6] | MIN_HEADER_BYTES;
        case ($urandom_range(0, 9))
            0, 1:    p.packet_length = r64[63:46];
            2:       p.packet_length = r64[45:40];
            default: p.packet_length = 18'd64 + r64[45:36] + r64[53:46];
        endcase
        p.identity_found = 1'b1;
        p.identity       = paced_id_shadow;
        p.now_ns         = wall_ns;

        if ($urandom_range(0, 99) >= 75)
        begin
            r64 = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                0: p.ethertype      = r64[15:0];
                1: p.linear_bytes   = r64[21:16] % MIN_HEADER_BYTES;
                2: p.identity_found = 1'b0;
                3: p.identity       = r64[63:32];
                default:
                begin
                    p.ethertype      = r64[15:0];
                    p.linear_bytes   = r64[33:16];
                    p.identity_found = r64[34];
                    p.identity       = $urandom;
                end
            endcase
        end
        return p;
    endfunction

    // Write one register and mirror it into the predictor; unused indexes fall through.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PACED_IDENTITY: paced_id_shadow     = value[IDENT_W-1:0];
            CFG_RATE_PRESENT:   rate_present_shadow = value[0];
            CFG_TENANT_RATE:    rate_shadow         = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    // Hold until every queued packet has gone and every verdict has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pkts_to_send.size() != 0 || s_tvalid || verdicts_due.size() != 0);
    endtask

    // Driver: present the next pending packet, hold it until accepted, and feed the
    // predictor on each accepted transaction. Idle at random between packets.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_verdict(pkt_on_bus);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pkts_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    pkt_on_bus = pkts_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{S_PAD_W{1'b0}}, pkt_on_bus};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: score each accepted result transaction against the oldest verdict due,
    // and stall the result channel at random.
    always @(posedge clk)
    begin
        verdict_rec_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    flag_mismatch("result with no packet outstanding", m_tdata[65:2], '0);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (m_tdata[1:0] !== want.verdict)
                        flag_mismatch("verdict", TIME_W'(m_tdata[1:0]),
                                      TIME_W'(want.verdict));
                    if (m_tdata[65:2] !== want.departure)
                        flag_mismatch("departure_time", m_tdata[65:2], want.departure);
                end
                results_seen++;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [63:0] r64;
        logic [RATE_W-1:0] rate;
        logic present;
        verdict_rec_t lost;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls heavily.
        send_idle_pct  = 19;
        recv_stall_pct = 64;
        @(negedge clk);

        // Reset settings: identity 5001, no rate entry, so the 10 Mbit/s default applies.
        pkts_to_send.push_back(mk_pkt(16'hFFFF, 18'd60, 18'd100, 1'b1, 32'd5001, 64'd100));
        pkts_to_send.push_back(mk_pkt(16'h0000, 18'd60, 18'd100, 1'b1, 32'd5001, 64'd200));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd33, 18'd100, 1'b1, 32'd5001,
                                      64'd300));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd100, 1'b0, 32'd5001,
                                      64'd400));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd100, 1'b1, 32'd5002,
                                      64'd500));
        // first stamp after reset: base is now_ns
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd34, 18'd1500, 1'b1, 32'd5001,
                                      64'd1000));
        // time behind the stored departure, empty packet
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd34, 18'd0, 1'b1, 32'd5001,
                                      64'd0));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'h3FFFF, 18'h3FFFF, 1'b1, 32'd5001,
                                      64'd5000000));
        // departure wraps past 2^64
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd40, 18'd1000, 1'b1, 32'd5001,
                                      64'hFFFF_FFFF_FFFF_FFF0));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd40, 18'd64, 1'b1, 32'd5001,
                                      64'd5));
        wait_idle();

        // Rate entry present with zero rate: the tenant is blocked.
        write_reg(CFG_RATE_PRESENT, 40'd1);
        write_reg(CFG_TENANT_RATE, 40'd0);
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd500, 1'b1, 32'd5001,
                                      64'd9000000));
        pkts_to_send.push_back(mk_pkt(16'h86DD, 18'd60, 18'd500, 1'b1, 32'd5001,
                                      64'd9000000));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd500, 1'b1, 32'd0,
                                      64'd9000000));
        wait_idle();

        // Slowest rate: largest delays.
        write_reg(CFG_TENANT_RATE, 40'd1);
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'h3FFFF, 1'b1, 32'd5001,
                                      64'd10000000));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd1, 1'b1, 32'd5001,
                                      64'd10000000));
        wait_idle();

        // Fastest rate.
        write_reg(CFG_TENANT_RATE, 40'hFF_FFFF_FFFF);
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'h3FFFF, 1'b1, 32'd5001,
                                      64'hFFFF_FFFF_FFFF_FFFF));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd0, 1'b1, 32'd5001,
                                      64'd20));
        wait_idle();

        // Identity 0 with junk above bit 31, then a write to the unused index.
        write_reg(CFG_PACED_IDENTITY, 40'hFF_0000_0000);
        write_reg(CFG_UNUSED_INDEX, 40'hFF_FFFF_FFFF);
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd700, 1'b1, 32'd0,
                                      64'd30000000));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd700, 1'b1, 32'd5001,
                                      64'd30000000));
        wait_idle();

        // All-ones identity, rate entry withdrawn (bit 0 clear): back to the default rate.
        write_reg(CFG_PACED_IDENTITY, 40'h00_FFFF_FFFF);
        write_reg(CFG_RATE_PRESENT, 40'hFF_FFFF_FFFE);
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd1200, 1'b1, 32'hFFFF_FFFF,
                                      64'd40000000));
        pkts_to_send.push_back(mk_pkt(ETHERTYPE_IPV4, 18'd60, 18'd1200, 1'b0, 32'hFFFF_FFFF,
                                      64'd40000000));
        wait_idle();

        // Random phases, each with fresh register settings; idling swaps sides after
        // a third of the phases and stops for the last third.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < RANDOM_PHASES / 3)
            begin
                send_idle_pct  = 19;
                recv_stall_pct = 64;
            end
            else if (phase < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct  = 64;
                recv_stall_pct = 19;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            r64 = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_PACED_IDENTITY, {r64[39:32], RESET_IDENTITY});
                1:       write_reg(CFG_PACED_IDENTITY, {r64[39:32], 32'h0000_0000});
                2:       write_reg(CFG_PACED_IDENTITY, {r64[39:32], 32'hFFFF_FFFF});
                default: write_reg(CFG_PACED_IDENTITY, r64[39:0]);
            endcase

            r64 = {$urandom, $urandom};
            present = ($urandom_range(0, 3) != 0);
            write_reg(CFG_RATE_PRESENT, {r64[39:1], present});

            r64 = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0:       rate = '0;
                1:       rate = 40'hFF_FFFF_FFFF;
                2:       rate = 40'd1 + $urandom_range(0, 4999);
                3, 4:    rate = r64[39:0];
                default: rate = 40'd1000 * $urandom_range(1000, 10000000);
            endcase
            write_reg(CFG_TENANT_RATE, rate);

            if ($urandom_range(0, 3) == 0)
            begin
                r64 = {$urandom, $urandom};
                write_reg(CFG_UNUSED_INDEX, r64[39:0]);
            end

            for (int k = 0; k < PACKETS_PER_PHASE; k++)
            begin
                pkts_to_send.push_back(draw_packet());
            end
            wait_idle();
        end

        // Drain: wait out any stragglers, then give late or extra results time to show.
        for (int i = 0; i < DRAIN_LIMIT; i++)
        begin
            if (pkts_to_send.size() == 0 && !s_tvalid && verdicts_due.size() == 0)
                break;
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pkts_to_send.size() != 0 || s_tvalid)
            flag_mismatch("packets never accepted", TIME_W'(pkts_to_send.size()), '0);
        while (verdicts_due.size() != 0)
        begin
            lost = verdicts_due.pop_front();
            flag_mismatch("verdict never delivered", '0, lost.departure);
        end

        $display("covered %0d packets: %0d passed unchanged, %0d stamped, %0d dropped",
                 results_seen, n_pass, n_stamp, n_drop);
        $display("%0d register writes over %0d random settings and the directed extremes",
                 reg_writes, RANDOM_PHASES);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: the slowest legal run finishes far sooner than this.
    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
